[rtl/fttw_pkg.sv]
package fttw_pkg;

    localparam int SCREEN_WIDTH   = 640;
    localparam int SCREEN_HEIGHT  = 480;
    localparam int FADE_WINDOW_MS = 460;

    localparam int WHITE_R = 232;
    localparam int WHITE_G = 240;
    localparam int WHITE_B = 255;

    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int PIX_W    = 16;
    localparam int A_W      = 9;
    localparam int COV_W    = 9;
    localparam int STYLE_W  = 3;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_IN_W = 40;

    localparam int N_STAGES = 8;

    localparam logic [STYLE_W-1:0] STYLE_MELT     = 3'd0;
    localparam logic [STYLE_W-1:0] STYLE_WIPE     = 3'd1;
    localparam logic [STYLE_W-1:0] STYLE_DISSOLVE = 3'd2;
    localparam logic [STYLE_W-1:0] STYLE_IRIS     = 3'd3;
    localparam logic [STYLE_W-1:0] STYLE_BLINDS   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_START  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCENE_END    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS_OUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_STYLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_STYLE     = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0]  frame_time;
        logic [TIME_W-1:0]  scene_start_time;
        logic [TIME_W-1:0]  scene_end_time;
        logic               suppress_outgoing;
        logic [STYLE_W-1:0] outgoing_style;
        logic [STYLE_W-1:0] incoming_style;
    } cfg_t;

endpackage

[rtl/fttw_prog.sv]
module fttw_prog (
    input  logic                           clk,
    input  fttw_pkg::cfg_t                 cfg,
    input  logic [1:0]                     en,
    output logic [fttw_pkg::A_W-1:0]       a,
    output logic [fttw_pkg::STYLE_W-1:0]   style,
    output logic                           active
);

    localparam int T_W       = 9;
    localparam int N_W       = T_W + 8;
    localparam int DIV_SHIFT = 16;
    localparam int DIV_MUL   = (1 << DIV_SHIFT) / fttw_pkg::FADE_WINDOW_MS;  // floor(2^16 / 460)
    localparam int PROD_W    = N_W + 9;
    localparam int A_W_Q     = 9;

    logic [fttw_pkg::TIME_W-1:0]  into;
    logic [fttw_pkg::TIME_W-1:0]  left;
    logic [T_W-1:0]               t_sel;
    logic [fttw_pkg::STYLE_W-1:0] style_sel;
    logic                         act_sel;
    logic [N_W-1:0]               num;
    logic [PROD_W-1:0]            prod;

    logic [N_W-1:0]               num_reg;
    logic [A_W_Q-1:0]             q0_reg;
    logic [fttw_pkg::STYLE_W-1:0] style1_reg;
    logic                         act1_reg;

    logic [N_W-1:0]               qmul;
    logic [N_W-1:0]               rem;
    logic [A_W_Q-1:0]             q;
    logic [fttw_pkg::A_W-1:0]     a_next;

    logic [fttw_pkg::A_W-1:0]     a_reg;
    logic [fttw_pkg::STYLE_W-1:0] style_reg;
    logic                         active_reg;

    // stage 1: window select and reciprocal estimate
    always_comb
    begin
        into = cfg.frame_time - cfg.scene_start_time;
        left = (cfg.scene_end_time > cfg.frame_time) ?
               (cfg.scene_end_time - cfg.frame_time) : '0;
        if (into < fttw_pkg::TIME_W'(fttw_pkg::FADE_WINDOW_MS))
        begin
            t_sel     = into[T_W-1:0];
            style_sel = cfg.incoming_style;
            act_sel   = 1'b1;
        end
        else if (!cfg.suppress_outgoing &&
                 left < fttw_pkg::TIME_W'(fttw_pkg::FADE_WINDOW_MS))
        begin
            t_sel     = left[T_W-1:0];
            style_sel = cfg.outgoing_style;
            act_sel   = 1'b1;
        end
        else
        begin
            t_sel     = '0;
            style_sel = cfg.incoming_style;
            act_sel   = 1'b0;
        end
        num  = {t_sel, 8'd0};
        prod = PROD_W'(num) * PROD_W'(DIV_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num_reg    <= num;
            q0_reg     <= A_W_Q'(prod >> DIV_SHIFT);
            style1_reg <= style_sel;
            act1_reg   <= act_sel;
        end
    end

    // stage 2: quotient correction, progress
    always_comb
    begin
        qmul   = N_W'(q0_reg) * N_W'(fttw_pkg::FADE_WINDOW_MS);
        rem    = num_reg - qmul;
        q      = (rem >= N_W'(fttw_pkg::FADE_WINDOW_MS)) ? (q0_reg + A_W_Q'(1)) : q0_reg;
        a_next = fttw_pkg::A_W'(10'd256 - 10'(q));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            a_reg      <= a_next;
            style_reg  <= style1_reg;
            active_reg <= act1_reg;
        end
    end

    assign a      = a_reg;
    assign style  = style_reg;
    assign active = active_reg;

endmodule

[rtl/fttw_cov.sv]
module fttw_cov (
    input  logic                           clk,
    input  logic [6:0]                     en,
    input  logic [fttw_pkg::X_W-1:0]       x,
    input  logic [fttw_pkg::Y_W-1:0]       y,
    input  logic [fttw_pkg::A_W-1:0]       a,
    input  logic [fttw_pkg::STYLE_W-1:0]   style,
    input  logic                           active,
    output logic [fttw_pkg::COV_W-1:0]     cov
);

    localparam int X_CENTRE   = fttw_pkg::SCREEN_WIDTH / 2;
    localparam int Y_CENTRE   = fttw_pkg::SCREEN_HEIGHT / 2;
    localparam int WIPE_SPAN  = fttw_pkg::SCREEN_WIDTH + 30;
    localparam int MELT_SPAN  = fttw_pkg::SCREEN_HEIGHT + 24;
    localparam int MOD12_MUL  = 171;   // ~ 2^11 / 12
    localparam int MOD31_MUL  = 2114;  // floor(2^16 / 31)
    localparam int DIV100_MUL = 655;   // floor(2^16 / 100)

    localparam int XW = fttw_pkg::X_W;
    localparam int YW = fttw_pkg::Y_W;
    localparam int CW = fttw_pkg::COV_W;
    localparam int SW = fttw_pkg::STYLE_W;

    function automatic logic [CW-1:0] clamp_cov(input logic signed [23:0] v);
        logic [CW-1:0] r;
        if (v < 24'sd0)
            r = '0;
        else if (v > 24'sd256)
            r = CW'(256);
        else
            r = v[CW-1:0];
        return r;
    endfunction

    // floor(k * 256 / 12) for k = y mod 12
    function automatic logic [7:0] blind_local(input logic [3:0] k);
        logic [7:0] r;
        case (k)
            4'd0:    r = 8'd0;
            4'd1:    r = 8'd21;
            4'd2:    r = 8'd42;
            4'd3:    r = 8'd64;
            4'd4:    r = 8'd85;
            4'd5:    r = 8'd106;
            4'd6:    r = 8'd128;
            4'd7:    r = 8'd149;
            4'd8:    r = 8'd170;
            4'd9:    r = 8'd192;
            4'd10:   r = 8'd213;
            4'd11:   r = 8'd234;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // stage 1
    logic signed [10:0] dx;
    logic signed [9:0]  dy;
    logic signed [21:0] dxsq;
    logic signed [19:0] dysq;
    logic [7:0]         hx, hy, hsum;
    logic [16:0]        yprod;

    logic [XW-1:0] x1_reg;
    logic [YW-1:0] y1_reg;
    logic [19:0]   xsq1_reg;
    logic [12:0]   x7_1_reg;
    logic [7:0]    h1_reg;
    logic [18:0]   dxsq1_reg;
    logic [16:0]   dysq1_reg;
    logic [5:0]    yq1_reg;

    always_comb
    begin
        dx    = $signed({1'b0, x}) - $signed(11'(X_CENTRE));
        dy    = $signed({1'b0, y}) - $signed(10'(Y_CENTRE));
        dxsq  = dx * dx;
        dysq  = dy * dy;
        hx    = 8'(x[7:0] * 8'd73);
        hy    = 8'(y[7:0] * 8'd151);
        hsum  = 8'(x[7:0] + y[7:0]);
        yprod = 17'(y) * 17'(MOD12_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg    <= x;
            y1_reg    <= y;
            xsq1_reg  <= 20'(x) * 20'(x);
            x7_1_reg  <= 13'(x) * 13'd7;
            h1_reg    <= hx ^ hy ^ {hsum[5:0], 2'b00};
            dxsq1_reg <= dxsq[18:0];
            dysq1_reg <= dysq[16:0];
            yq1_reg   <= 6'(yprod >> 11);
        end
    end

    // stage 2
    logic [9:0] yrem0;
    logic [9:0] yrem;

    logic [XW-1:0] x2_reg;
    logic [YW-1:0] y2_reg;
    logic [7:0]    h2_reg;
    logic [15:0]   v2_reg;
    logic [19:0]   d2_2_reg;
    logic [7:0]    local2_reg;

    always_comb
    begin
        yrem0 = 10'(y1_reg) - 10'(yq1_reg) * 10'd12;
        yrem  = (yrem0 >= 10'd12) ? (yrem0 - 10'd12) : yrem0;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            x2_reg     <= x1_reg;
            y2_reg     <= y1_reg;
            h2_reg     <= h1_reg;
            v2_reg     <= 16'(x7_1_reg) + 16'(xsq1_reg >> 5);
            d2_2_reg   <= 20'(dxsq1_reg) + 20'(dysq1_reg);
            local2_reg <= blind_local(yrem[3:0]);
        end
    end

    // stage 3: progress joins the pixel
    logic [17:0]        wprod;
    logic [16:0]        iprod;
    logic [17:0]        mprod;
    logic [27:0]        vprod;
    logic signed [10:0] ddiff;
    logic signed [10:0] bdiff;

    logic [XW-1:0]      x3_reg;
    logic [YW-1:0]      y3_reg;
    logic [SW-1:0]      style3_reg;
    logic               act3_reg;
    logic signed [11:0] edge3_reg;
    logic [7:0]         r3_reg;
    logic [8:0]         ab3_reg;
    logic [15:0]        v3_reg;
    logic [11:0]        qv3_reg;
    logic [19:0]        d2_3_reg;
    logic [CW-1:0]      covd3_reg;
    logic [CW-1:0]      covb3_reg;

    always_comb
    begin
        wprod = 18'(a) * 18'(WIPE_SPAN);
        iprod = 17'(a) * 17'd205;
        mprod = 18'(a) * 18'(MELT_SPAN);
        vprod = 28'(v2_reg) * 28'(MOD31_MUL);
        ddiff = $signed({2'b0, a}) - $signed({3'b0, h2_reg});
        bdiff = $signed({2'b0, a}) - $signed({3'b0, local2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            style3_reg <= style;
            act3_reg   <= active;
            edge3_reg  <= $signed({2'b0, wprod[17:8]}) - 12'sd15;
            r3_reg     <= iprod[15:8];
            ab3_reg    <= mprod[16:8];
            v3_reg     <= v2_reg;
            qv3_reg    <= 12'(vprod >> 16);
            d2_3_reg   <= d2_2_reg;
            covd3_reg  <= clamp_cov(24'(ddiff) * 24'sd10);
            covb3_reg  <= clamp_cov(24'(bdiff) * 24'sd12);
        end
    end

    // stage 4
    logic signed [11:0] we;
    logic [15:0]        rsq;
    logic [16:0]        mrem0;
    logic [16:0]        mrem;

    logic [YW-1:0]      y4_reg;
    logic [SW-1:0]      style4_reg;
    logic               act4_reg;
    logic [CW-1:0]      covd4_reg;
    logic [CW-1:0]      covb4_reg;
    logic [CW-1:0]      covw4_reg;
    logic signed [21:0] idiff4_reg;
    logic [6:0]         f4_reg;
    logic [8:0]         ab4_reg;

    always_comb
    begin
        we    = edge3_reg - $signed({2'b0, x3_reg});
        rsq   = 16'(r3_reg) * 16'(r3_reg);
        mrem0 = 17'(v3_reg) - 17'(qv3_reg) * 17'd31;
        mrem  = (mrem0 >= 17'd31) ? (mrem0 - 17'd31) : mrem0;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            y4_reg     <= y3_reg;
            style4_reg <= style3_reg;
            act4_reg   <= act3_reg;
            covd4_reg  <= covd3_reg;
            covb4_reg  <= covb3_reg;
            covw4_reg  <= clamp_cov(24'(we) * 24'sd24);
            idiff4_reg <= $signed({6'b0, rsq}) - $signed({2'b0, d2_3_reg});
            f4_reg     <= 7'd80 + 7'(mrem);
            ab4_reg    <= ab3_reg;
        end
    end

    // stage 5
    logic signed [21:0] ish;

    logic [YW-1:0] y5_reg;
    logic [SW-1:0] style5_reg;
    logic          act5_reg;
    logic [CW-1:0] covd5_reg;
    logic [CW-1:0] covb5_reg;
    logic [CW-1:0] covw5_reg;
    logic [CW-1:0] covi5_reg;
    logic [15:0]   mp5_reg;

    assign ish = idiff4_reg >>> 6;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            y5_reg     <= y4_reg;
            style5_reg <= style4_reg;
            act5_reg   <= act4_reg;
            covd5_reg  <= covd4_reg;
            covb5_reg  <= covb4_reg;
            covw5_reg  <= covw4_reg;
            covi5_reg  <= clamp_cov(24'(ish));
            mp5_reg    <= 16'(ab4_reg) * 16'(f4_reg);
        end
    end

    // stage 6
    logic [25:0] fprod;

    logic [YW-1:0] y6_reg;
    logic [SW-1:0] style6_reg;
    logic          act6_reg;
    logic [CW-1:0] covd6_reg;
    logic [CW-1:0] covb6_reg;
    logic [CW-1:0] covw6_reg;
    logic [CW-1:0] covi6_reg;
    logic [15:0]   mp6_reg;
    logic [9:0]    fq6_reg;

    assign fprod = 26'(mp5_reg) * 26'(DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            y6_reg     <= y5_reg;
            style6_reg <= style5_reg;
            act6_reg   <= act5_reg;
            covd6_reg  <= covd5_reg;
            covb6_reg  <= covb5_reg;
            covw6_reg  <= covw5_reg;
            covi6_reg  <= covi5_reg;
            mp6_reg    <= mp5_reg;
            fq6_reg    <= 10'(fprod >> 16);
        end
    end

    // stage 7: melt front, pattern select
    logic [15:0]        frem;
    logic [9:0]         front;
    logic signed [10:0] me;
    logic [CW-1:0]      covm;
    logic [CW-1:0]      cov_sel;
    logic [CW-1:0]      cov_reg;

    always_comb
    begin
        frem  = mp6_reg - 16'(fq6_reg) * 16'd100;
        front = (frem >= 16'd100) ? (fq6_reg + 10'd1) : fq6_reg;
        me    = $signed({1'b0, front}) - $signed({2'b0, y6_reg});
        covm  = clamp_cov(24'(me) * 24'sd24);
        unique case (style6_reg)
            fttw_pkg::STYLE_WIPE:     cov_sel = covw6_reg;
            fttw_pkg::STYLE_DISSOLVE: cov_sel = covd6_reg;
            fttw_pkg::STYLE_IRIS:     cov_sel = covi6_reg;
            fttw_pkg::STYLE_BLINDS:   cov_sel = covb6_reg;
            default:                  cov_sel = covm;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
            cov_reg <= act6_reg ? cov_sel : '0;
    end

    assign cov = cov_reg;

endmodule

[rtl/fttw_blend.sv]
module fttw_blend (
    input  logic                         clk,
    input  logic [7:0]                   en,
    input  logic [fttw_pkg::PIX_W-1:0]   pixel_in,
    input  logic [fttw_pkg::COV_W-1:0]   cov,
    output logic [fttw_pkg::PIX_W-1:0]   pixel_out
);

    localparam int PW    = fttw_pkg::PIX_W;
    localparam int DEPTH = fttw_pkg::N_STAGES - 1;

    function automatic logic [7:0] toward(input logic [7:0] ch, input logic [7:0] white,
                                          input logic [fttw_pkg::COV_W-1:0] c);
        logic signed [9:0]  d;
        logic signed [19:0] prod;
        logic signed [19:0] sum;
        d    = $signed({2'b0, white}) - $signed({2'b0, ch});
        prod = 20'(d) * $signed({11'b0, c});
        sum  = $signed({12'b0, ch}) + (prod >>> 8);
        return sum[7:0];
    endfunction

    logic [PW-1:0] pix_reg [DEPTH];
    logic [PW-1:0] out_reg;

    logic [4:0] r5, b5;
    logic [5:0] g6;
    logic [7:0] r8, g8, b8;

    always_ff @(posedge clk)
    begin
        if (en[0])
            pix_reg[0] <= pixel_in;
    end

    for (genvar k = 1; k < DEPTH; k++)
    begin : g_delay
        always_ff @(posedge clk)
        begin
            if (en[k])
                pix_reg[k] <= pix_reg[k-1];
        end
    end

    // channels widen by bit replication, repack by truncation
    always_comb
    begin
        r5 = pix_reg[DEPTH-1][15:11];
        g6 = pix_reg[DEPTH-1][10:5];
        b5 = pix_reg[DEPTH-1][4:0];
        r8 = toward({r5, r5[4:2]}, 8'(fttw_pkg::WHITE_R), cov);
        g8 = toward({g6, g6[5:4]}, 8'(fttw_pkg::WHITE_G), cov);
        b8 = toward({b5, b5[4:2]}, 8'(fttw_pkg::WHITE_B), cov);
    end

    always_ff @(posedge clk)
    begin
        if (en[DEPTH])
            out_reg <= {r8[7:3], g8[7:2], b8[7:3]};
    end

    assign pixel_out = out_reg;

endmodule

[rtl/fade_to_white_transition_pixel.sv]
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata: pixel_x, pixel_y, pixel_in
// m_*       out  m_tvalid / m_tready    m_tdata: pixel_out
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled, through the fixed stage pipeline.
// The melt path (mod 31 and divide by 100 as reciprocal multiplies) sets the depth.
// rst_n clears the configuration registers and all stage valid bits; no clearing pass.
// Each stage holds only while it is full and the next one cannot take its item,
// so bubbles close up behind a stalled output; cfg_ready is always high.
module fade_to_white_transition_pixel (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fttw_pkg::TDATA_IN_W-1:0]     s_tdata,   // pixel_x, pixel_y, pixel_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fttw_pkg::PIX_W-1:0]          m_tdata,   // pixel_out
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fttw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fttw_pkg::TIME_W-1:0]         cfg_data
);

    localparam int NS = fttw_pkg::N_STAGES;

    fttw_pkg::cfg_t cfg_reg;
    fttw_pkg::cfg_t cfg_next;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;

    logic [fttw_pkg::X_W-1:0]     px;
    logic [fttw_pkg::Y_W-1:0]     py;
    logic [fttw_pkg::PIX_W-1:0]   pin;
    logic [fttw_pkg::A_W-1:0]     prog_a;
    logic [fttw_pkg::STYLE_W-1:0] prog_style;
    logic                         prog_active;
    logic [fttw_pkg::COV_W-1:0]   cov;

    assign px  = s_tdata[9:0];
    assign py  = s_tdata[18:10];
    assign pin = s_tdata[34:19];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                fttw_pkg::CFG_FRAME_TIME:   cfg_next.frame_time        = cfg_data;
                fttw_pkg::CFG_SCENE_START:  cfg_next.scene_start_time  = cfg_data;
                fttw_pkg::CFG_SCENE_END:    cfg_next.scene_end_time    = cfg_data;
                fttw_pkg::CFG_SUPPRESS_OUT: cfg_next.suppress_outgoing = cfg_data[0];
                fttw_pkg::CFG_OUT_STYLE:    cfg_next.outgoing_style    = cfg_data[2:0];
                fttw_pkg::CFG_IN_STYLE:     cfg_next.incoming_style    = cfg_data[2:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NS; k++)
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NS-1];

    fttw_prog u_prog (
        .clk    (clk),
        .cfg    (cfg_reg),
        .en     (stage_en[1:0]),
        .a      (prog_a),
        .style  (prog_style),
        .active (prog_active)
    );

    fttw_cov u_cov (
        .clk    (clk),
        .en     (stage_en[6:0]),
        .x      (px),
        .y      (py),
        .a      (prog_a),
        .style  (prog_style),
        .active (prog_active),
        .cov    (cov)
    );

    fttw_blend u_blend (
        .clk       (clk),
        .en        (stage_en[7:0]),
        .pixel_in  (pin),
        .cov       (cov),
        .pixel_out (m_tdata)
    );

endmodule

[rtl/fttw_chk.sv]
module fttw_chk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [fttw_pkg::PIX_W-1:0]          m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side only backs up behind a stalled output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // register writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // an item leaving the output opens the input in the same cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> s_tready)
        else $error("input closed while output drained");

endmodule

bind fade_to_white_transition_pixel fttw_chk u_chk (.*);
